// File: sv/selective_repeat_send_window_macros.svh
// assertion macros for the send window checker
`ifndef SELECTIVE_REPEAT_SEND_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_SEND_WINDOW_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define SRSW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define SRSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/srsw_pkg.sv
`timescale 1ns / 1ps

package srsw_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 16;

  localparam logic [10:0] MAX_CHUNK   = 11'd1456;
  localparam logic [15:0] AGE_MAX     = 16'hFFFF;
  localparam logic [1:0]  ACK_TYPE    = 2'd3;

  localparam logic [4:0]  WIN_RST     = 5'd16;
  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam logic [31:0] TOTAL_RST   = 32'd0;
  localparam logic [10:0] CHUNK_RST   = 11'd1456;

  typedef enum logic [1:0] {
    CFG_WINDOW_SIZE = 2'd0,
    CFG_TIMEOUT_MS  = 2'd1,
    CFG_TOTAL_BYTES = 2'd2,
    CFG_CHUNK_BYTES = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_SEND   = 2'd0,
    KIND_RETX   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_RD,
    ST_EV,
    ST_POP,
    ST_STAT
  } state_e;

  typedef struct packed {
    logic        acked;
    logic [15:0] age;
    logic [10:0] len;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic fill;
    logic rd;
    logic scan;
    logic pop;
    logic stat;
  } cmd_t;

  typedef struct packed {
    logic fill_more;
    logic occ_zero;
    logic scan_last;
    logic need_rtx;
    logic emit_ok;
  } sts_t;

endpackage

// File: sv/srsw_ctrl.sv
`timescale 1ns / 1ps

module srsw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  srsw_pkg::sts_t   sts_i,
  output srsw_pkg::cmd_t   cmd_o
);

  srsw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srsw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      srsw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = srsw_pkg::ST_FILL;
        end
      end
      srsw_pkg::ST_FILL: begin
        if (sts_i.fill_more) begin
          cmd_o.fill = sts_i.emit_ok;
        end else if (sts_i.occ_zero) begin
          state_d = srsw_pkg::ST_POP;
        end else begin
          state_d = srsw_pkg::ST_RD;
        end
      end
      srsw_pkg::ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = srsw_pkg::ST_EV;
      end
      srsw_pkg::ST_EV: begin
        // a retransmit waits for room in the output register
        if (!sts_i.need_rtx || sts_i.emit_ok) begin
          cmd_o.scan = 1'b1;
          state_d    = sts_i.scan_last ? srsw_pkg::ST_POP : srsw_pkg::ST_RD;
        end
      end
      srsw_pkg::ST_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = srsw_pkg::ST_STAT;
      end
      srsw_pkg::ST_STAT: begin
        if (sts_i.emit_ok) begin
          cmd_o.stat = 1'b1;
          state_d    = srsw_pkg::ST_IDLE;
        end
      end
      default: state_d = srsw_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: sv/srsw_dp.sv
`timescale 1ns / 1ps

module srsw_dp #(
  parameter int unsigned WINDOW_DEPTH = srsw_pkg::WINDOW_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i,
  input  logic             has_packet_i,
  input  logic [1:0]       pkt_type_i,
  input  logic [31:0]      pkt_seq_i,
  input  logic [9:0]       elapsed_ms_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       kind_o,
  output logic [31:0]      seq_o,
  output logic [10:0]      length_o,
  output logic [4:0]       occupancy_o,
  output logic             done_res_o,
  output logic             last_o,
  input  srsw_pkg::cmd_t   cmd_i,
  output srsw_pkg::sts_t   sts_o
);

  localparam int unsigned SW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    if (32'(s) == WINDOW_DEPTH - 1) begin
      return '0;
    end
    return s + SW'(1);
  endfunction

  // configuration
  logic [4:0]  win_size_q;
  logic [15:0] timeout_q;
  logic [31:0] total_q;
  logic [10:0] chunk_q;

  // window state
  logic [31:0]   head_seq_q, next_seq_q, bytes_sent_q;
  logic [CW-1:0] occ_q;
  logic [SW-1:0] head_slot_q, next_slot_q;

  // scan state
  logic [SW-1:0] scan_slot_q;
  logic [31:0]   scan_seq_q;
  logic [CW-1:0] idx_q, pop_cnt_q;
  logic          prefix_q;

  // latched request
  logic        has_pkt_q;
  logic [1:0]  type_q;
  logic [31:0] pkt_seq_q;
  logic [9:0]  elapsed_q;

  srsw_pkg::entry_t mem_q [WINDOW_DEPTH];
  srsw_pkg::entry_t rdata_q;

  logic             out_valid_q;
  srsw_pkg::kind_e  kind_q;
  logic [31:0]      seq_q;
  logic [10:0]      length_q;
  logic [4:0]       occ_out_q;
  logic             done_q;
  logic             last_q;

  // combinational
  logic [31:0]      win32;
  logic [CW-1:0]    win;
  logic [10:0]      chunk_eff;
  logic [31:0]      rem;
  logic [10:0]      fill_len;
  logic [16:0]      age_sum;
  logic [15:0]      age_new;
  logic             is_ack, proceed, hit, acked_new, need_rtx, emit_ok, out_set;
  logic [CW:0]      pop_sum;
  logic [SW-1:0]    head_slot_new;
  logic [31:0]      occ_ext;
  logic             mem_we;
  logic [SW-1:0]    mem_waddr;
  srsw_pkg::entry_t mem_wdata;

  always_comb begin
    win32 = (32'(win_size_q) > WINDOW_DEPTH) ? 32'(WINDOW_DEPTH) : 32'(win_size_q);
    win   = CW'(win32);

    if (chunk_q == 11'd0) begin
      chunk_eff = 11'd1;
    end else if (chunk_q > srsw_pkg::MAX_CHUNK) begin
      chunk_eff = srsw_pkg::MAX_CHUNK;
    end else begin
      chunk_eff = chunk_q;
    end
    rem      = total_q - bytes_sent_q;
    fill_len = (rem < 32'(chunk_eff)) ? rem[10:0] : chunk_eff;

    age_sum   = 17'(rdata_q.age) + 17'(elapsed_q);
    age_new   = age_sum[16] ? srsw_pkg::AGE_MAX : age_sum[15:0];
    is_ack    = has_pkt_q && (type_q == srsw_pkg::ACK_TYPE);
    proceed   = !has_pkt_q || (type_q == srsw_pkg::ACK_TYPE);
    hit       = is_ack && (pkt_seq_q == scan_seq_q);
    acked_new = rdata_q.acked | hit;
    need_rtx  = proceed && !acked_new && (age_new >= timeout_q);

    emit_ok = !out_valid_q || out_ready_i;
    out_set = cmd_i.fill | cmd_i.stat | (cmd_i.scan & need_rtx);

    pop_sum       = (CW + 1)'(head_slot_q) + (CW + 1)'(pop_cnt_q);
    head_slot_new = (pop_sum >= (CW + 1)'(WINDOW_DEPTH)) ?
                    SW'(pop_sum - (CW + 1)'(WINDOW_DEPTH)) : SW'(pop_sum);

    occ_ext = 32'(occ_q);

    mem_we    = cmd_i.fill | cmd_i.scan;
    mem_waddr = cmd_i.fill ? next_slot_q : scan_slot_q;
    if (cmd_i.fill) begin
      mem_wdata = '{acked: 1'b0, age: 16'd0, len: fill_len};
    end else begin
      mem_wdata = '{acked: acked_new, age: (need_rtx ? 16'd0 : age_new), len: rdata_q.len};
    end
  end

  assign sts_o.fill_more = (occ_q < win) && (bytes_sent_q < total_q);
  assign sts_o.occ_zero  = (occ_q == '0);
  assign sts_o.scan_last = ((idx_q + CW'(1)) == occ_q);
  assign sts_o.need_rtx  = need_rtx;
  assign sts_o.emit_ok   = emit_ok;

  // window memory: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[scan_slot_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q   <= srsw_pkg::WIN_RST;
      timeout_q    <= srsw_pkg::TIMEOUT_RST;
      total_q      <= srsw_pkg::TOTAL_RST;
      chunk_q      <= srsw_pkg::CHUNK_RST;
      head_seq_q   <= '0;
      next_seq_q   <= '0;
      bytes_sent_q <= '0;
      occ_q        <= '0;
      head_slot_q  <= '0;
      next_slot_q  <= '0;
      scan_slot_q  <= '0;
      idx_q        <= '0;
      pop_cnt_q    <= '0;
      prefix_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (srsw_pkg::cfg_idx_e'(cfg_idx_i))
          srsw_pkg::CFG_WINDOW_SIZE: win_size_q <= cfg_data_i[4:0];
          srsw_pkg::CFG_TIMEOUT_MS:  timeout_q  <= cfg_data_i[15:0];
          srsw_pkg::CFG_TOTAL_BYTES: total_q    <= cfg_data_i;
          srsw_pkg::CFG_CHUNK_BYTES: chunk_q    <= cfg_data_i[10:0];
          default: ;
        endcase
      end

      if (cmd_i.capture) begin
        scan_slot_q <= head_slot_q;
        idx_q       <= '0;
        pop_cnt_q   <= '0;
        prefix_q    <= 1'b1;
      end

      if (cmd_i.fill) begin
        next_seq_q   <= next_seq_q + 32'd1;
        next_slot_q  <= slot_inc(next_slot_q);
        bytes_sent_q <= bytes_sent_q + 32'(fill_len);
        occ_q        <= occ_q + CW'(1);
      end

      if (cmd_i.scan) begin
        idx_q       <= idx_q + CW'(1);
        scan_slot_q <= slot_inc(scan_slot_q);
        // count the run of acked entries from the head
        if (prefix_q && acked_new) begin
          pop_cnt_q <= pop_cnt_q + CW'(1);
        end else begin
          prefix_q <= 1'b0;
        end
      end

      if (cmd_i.pop && proceed) begin
        head_seq_q  <= head_seq_q + 32'(pop_cnt_q);
        head_slot_q <= head_slot_new;
        occ_q       <= occ_q - pop_cnt_q;
      end

      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      has_pkt_q  <= has_packet_i;
      type_q     <= pkt_type_i;
      pkt_seq_q  <= pkt_seq_i;
      elapsed_q  <= elapsed_ms_i;
      scan_seq_q <= head_seq_q;
    end else if (cmd_i.scan) begin
      scan_seq_q <= scan_seq_q + 32'd1;
    end

    if (cmd_i.fill) begin
      kind_q    <= srsw_pkg::KIND_SEND;
      seq_q     <= next_seq_q;
      length_q  <= fill_len;
      occ_out_q <= 5'd0;
      done_q    <= 1'b0;
      last_q    <= 1'b0;
    end else if (cmd_i.scan && need_rtx) begin
      kind_q    <= srsw_pkg::KIND_RETX;
      seq_q     <= scan_seq_q;
      length_q  <= rdata_q.len;
      occ_out_q <= 5'd0;
      done_q    <= 1'b0;
      last_q    <= 1'b0;
    end else if (cmd_i.stat) begin
      kind_q    <= srsw_pkg::KIND_STATUS;
      seq_q     <= 32'd0;
      length_q  <= 11'd0;
      occ_out_q <= occ_ext[4:0];
      done_q    <= (bytes_sent_q >= total_q) && (occ_q == '0);
      last_q    <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign seq_o       = seq_q;
  assign length_o    = length_q;
  assign occupancy_o = occ_out_q;
  assign done_res_o  = done_q;
  assign last_o      = last_q;

endmodule

// File: sv/selective_repeat_send_window.sv
// the next request is taken once the round's status is loaded
// a round issues new sends (up to WINDOW_DEPTH), then scans each window entry after the fill,
//   then pops the acked head (not after a non-ack packet) and loads the status result
// the window memory is read and written back once per entry
// an output register holds each result; a stalled result stops the round at the next result to load until taken
// reset: async active low, empty window, counters zero, registers to their defaults
`timescale 1ns / 1ps

module selective_repeat_send_window #(
  parameter int unsigned WINDOW_DEPTH = srsw_pkg::WINDOW_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        has_packet_i,
  input  logic [1:0]  pkt_type_i,
  input  logic [31:0] pkt_seq_i,
  input  logic [9:0]  elapsed_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] seq_o,
  output logic [10:0] length_o,
  output logic [4:0]  occupancy_o,
  output logic        done_res_o,
  output logic        last_o
);

  srsw_pkg::cmd_t cmd;
  srsw_pkg::sts_t sts;

  srsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srsw_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .has_packet_i (has_packet_i),
    .pkt_type_i   (pkt_type_i),
    .pkt_seq_i    (pkt_seq_i),
    .elapsed_ms_i (elapsed_ms_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .seq_o        (seq_o),
    .length_o     (length_o),
    .occupancy_o  (occupancy_o),
    .done_res_o   (done_res_o),
    .last_o       (last_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

// File: sv/srsw_chk.sv
`timescale 1ns / 1ps
`include "selective_repeat_send_window_macros.svh"

module srsw_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_idx_i,
  input logic [31:0] cfg_data_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        has_packet_i,
  input logic [1:0]  pkt_type_i,
  input logic [31:0] pkt_seq_i,
  input logic [9:0]  elapsed_ms_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [31:0] seq_o,
  input logic [10:0] length_o,
  input logic [4:0]  occupancy_o,
  input logic        done_res_o,
  input logic        last_o
);

  // a stalled result holds
  `SRSW_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(kind_o) && $stable(seq_o) && $stable(length_o) && $stable(last_o), "result changed while stalled")

  // last marks the status result and nothing else
  `SRSW_ASSERT_NOW(a_last_status, out_valid_o, last_o == (kind_o == srsw_pkg::KIND_STATUS), "last and status kind disagree")

  // send orders carry a real length and no status fields
  `SRSW_ASSERT_NOW(a_order_fields, out_valid_o && !last_o, length_o != 11'd0 && occupancy_o == 5'd0 && !done_res_o, "bad send order fields")

  // a round keeps the block busy for at least the next cycle
  `SRSW_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o, "request taken while round in progress")

endmodule

bind selective_repeat_send_window srsw_chk u_chk (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import srsw_pkg::*;

  localparam int unsigned DEPTH         = WINDOW_DEPTH_DEF;
  localparam int unsigned RAND_ITEMS    = 430;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 60;

  // header types other than an ack; the block only looks for an ack
  localparam logic [1:0] PKT_OTHER0 = 2'd0;
  localparam logic [1:0] PKT_OTHER1 = 2'd1;
  localparam logic [1:0] PKT_OTHER2 = 2'd2;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] seq;
    logic [10:0] length;
    logic [4:0]  occ;
    logic        done;
    logic        last;
  } order_t;

  typedef struct packed {
    logic        is_cfg;
    logic [31:0] win;
    logic [31:0] tmo;
    logic [31:0] total;
    logic [31:0] chunk;
    logic        has_pkt;
    logic [1:0]  ptype;
    logic [31:0] pseq;
    logic [9:0]  el;
    logic        typed;
    logic [4:0]  occ;
    logic        done;
  } step_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_e;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [1:0]  cfg_idx_i    = CFG_WINDOW_SIZE;
  logic [31:0] cfg_data_i   = '0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic        has_packet_i = 1'b0;
  logic [1:0]  pkt_type_i   = PKT_OTHER0;
  logic [31:0] pkt_seq_i    = '0;
  logic [9:0]  elapsed_ms_i = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [1:0]  kind_o;
  logic [31:0] seq_o;
  logic [10:0] length_o;
  logic [4:0]  occupancy_o;
  logic        done_res_o;
  logic        last_o;

  selective_repeat_send_window dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // window model
  logic [4:0]  win_cfg     = WIN_RST;
  logic [15:0] timeout_cfg = TIMEOUT_RST;
  logic [31:0] total_cfg   = TOTAL_RST;
  logic [10:0] chunk_cfg   = CHUNK_RST;
  logic [31:0] base_seq    = '0;
  logic [31:0] issue_seq   = '0;
  logic [31:0] bytes_out   = '0;
  int unsigned in_flight   = 0;
  logic        slot_acked_m [DEPTH];
  logic [15:0] slot_age_m   [DEPTH];
  logic [10:0] slot_len_m   [DEPTH];

  order_t      orders_due[$];
  int          errors     = 0;
  int          burst_left = 0;
  logic        typed_now  = 1'b0;
  logic [4:0]  typed_occ  = '0;
  logic        typed_done = 1'b0;

  function automatic order_t make_order(kind_e k, logic [31:0] s, logic [10:0] l,
                                        logic [4:0] o, logic d, logic f);
    order_t r;
    r.kind   = k;
    r.seq    = s;
    r.length = l;
    r.occ    = o;
    r.done   = d;
    r.last   = f;
    return r;
  endfunction

  // one round: fill, age, take the header, resend stale entries, pop acked head
  task automatic advance_window(input logic has_pkt, input logic [1:0] ptype,
                                input logic [31:0] pseq, input logic [9:0] el,
                                output order_t res[$]);
    int unsigned lim, chunk, remain, len, slot;
    logic [31:0] off, sq;
    logic [16:0] aged;
    bit          resolve;
    res.delete();
    resolve = 1'b1;
    lim     = (win_cfg > DEPTH) ? DEPTH : win_cfg;
    chunk   = (chunk_cfg == 0) ? 1 : ((chunk_cfg > MAX_CHUNK) ? MAX_CHUNK : chunk_cfg);
    while (in_flight < lim && bytes_out < total_cfg) begin
      remain = total_cfg - bytes_out;
      len    = (remain < chunk) ? remain : chunk;
      slot   = issue_seq % DEPTH;
      slot_acked_m[slot] = 1'b0;
      slot_age_m[slot]   = '0;
      slot_len_m[slot]   = len[10:0];
      res.push_back(make_order(KIND_SEND, issue_seq, len[10:0], '0, 1'b0, 1'b0));
      issue_seq++;
      bytes_out += len;
      in_flight++;
    end
    for (int i = 0; i < in_flight; i++) begin
      sq   = base_seq + i;
      slot = sq % DEPTH;
      aged = slot_age_m[slot] + el;
      slot_age_m[slot] = (aged > AGE_MAX) ? AGE_MAX : aged[15:0];
    end
    if (has_pkt) begin
      if (ptype != ACK_TYPE || in_flight == 0) begin
        resolve = 1'b0;
      end else begin
        off = pseq - base_seq;
        if (off < in_flight) slot_acked_m[pseq % DEPTH] = 1'b1;
      end
    end
    if (resolve) begin
      for (int i = 0; i < in_flight; i++) begin
        sq   = base_seq + i;
        slot = sq % DEPTH;
        if (!slot_acked_m[slot] && slot_age_m[slot] >= timeout_cfg) begin
          res.push_back(make_order(KIND_RETX, sq, slot_len_m[slot], '0, 1'b0, 1'b0));
          slot_age_m[slot] = '0;
        end
      end
      while (in_flight > 0 && slot_acked_m[base_seq % DEPTH]) begin
        base_seq++;
        in_flight--;
      end
    end
    res.push_back(make_order(KIND_STATUS, '0, '0, 5'(in_flight),
                             (bytes_out >= total_cfg && in_flight == 0), 1'b1));
  endtask

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    order_t round_res[$];
    order_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        advance_window(has_packet_i, pkt_type_i, pkt_seq_i, elapsed_ms_i, round_res);
        if (typed_now)
          orders_due.push_back(make_order(KIND_STATUS, '0, '0, typed_occ, typed_done, 1'b1));
        else
          foreach (round_res[i]) orders_due.push_back(round_res[i]);
      end
      if (out_valid_o && out_ready_i) begin
        if (orders_due.size() == 0) begin
          $display("%0t: result with nothing expected, got kind %0d seq %0d", $time,
                   kind_o, seq_o);
          errors++;
        end else begin
          want = orders_due[0];
          orders_due.delete(0);
          check_field("kind", want.kind, kind_o);
          check_field("seq", want.seq, seq_o);
          check_field("length", want.length, length_o);
          check_field("occupancy", want.occ, occupancy_o);
          check_field("done_res", want.done, done_res_o);
          check_field("last", want.last, last_o);
        end
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_WINDOW_SIZE: win_cfg     = data[4:0];
      CFG_TIMEOUT_MS:  timeout_cfg = data[15:0];
      CFG_TOTAL_BYTES: total_cfg   = data;
      default:         chunk_cfg   = data[10:0];
    endcase
    @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [31:0] w, input logic [31:0] t,
                              input logic [31:0] tot, input logic [31:0] ch);
    write_reg(CFG_WINDOW_SIZE, w);
    write_reg(CFG_TIMEOUT_MS, t);
    write_reg(CFG_TOTAL_BYTES, tot);
    write_reg(CFG_CHUNK_BYTES, ch);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (orders_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // bursts of requests with gaps, now and then hold off until all results are back
  task automatic pace_sender();
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end else if ($urandom_range(0, 39) == 0) begin
      wait_idle();
    end
    burst_left--;
  endtask

  task automatic drive_request(input logic h, input logic [1:0] ty, input logic [31:0] s,
                               input logic [9:0] e, input logic typed,
                               input logic [4:0] occ, input logic done);
    typed_now     = typed;
    typed_occ     = occ;
    typed_done    = done;
    in_valid_i   <= 1'b1;
    has_packet_i <= h;
    pkt_type_i   <= ty;
    pkt_seq_i    <= s;
    elapsed_ms_i <= e;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic step_t cfg_row(logic [31:0] w, logic [31:0] t, logic [31:0] tot,
                                    logic [31:0] ch);
    step_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.win    = w;
    r.tmo    = t;
    r.total  = tot;
    r.chunk  = ch;
    return r;
  endfunction

  function automatic step_t req_row(logic h, logic [1:0] ty, logic [31:0] s, logic [9:0] e);
    step_t r;
    r         = '0;
    r.has_pkt = h;
    r.ptype   = ty;
    r.pseq    = s;
    r.el      = e;
    return r;
  endfunction

  function automatic step_t chk_row(logic h, logic [1:0] ty, logic [31:0] s, logic [9:0] e,
                                    logic [4:0] occ, logic done);
    step_t r;
    r       = req_row(h, ty, s, e);
    r.typed = 1'b1;
    r.occ   = occ;
    r.done  = done;
    return r;
  endfunction

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    rx_mode_e    mode;
    int unsigned hold, beat;
    beat = 0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      hold = $urandom_range(20, 200);
      repeat (hold) begin
        @(negedge clk_i);
        beat++;
        case (mode)
          RX_OPEN:   out_ready_i <= 1'b1;
          RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready_i <= ($urandom_range(0, 5) == 0);
          default:   out_ready_i <= (beat % 4 != 0);
        endcase
      end
    end
  end

  initial begin
    step_t       plan[$];
    logic        h;
    logic [1:0]  ty;
    logic [31:0] s, w, t, tot, ch;
    logic [9:0]  el;
    int unsigned rand_items, span, ack_share, pick;
    bit          aging;

    for (int i = 0; i < DEPTH; i++) begin
      slot_acked_m[i] = 1'b0;
      slot_age_m[i]   = '0;
      slot_len_m[i]   = '0;
    end

    // nothing to send yet: every round is a bare status with done set
    plan.push_back(chk_row(1'b0, PKT_OTHER0, 32'd0, 10'd0, 5'd0, 1'b1));
    plan.push_back(chk_row(1'b1, ACK_TYPE, 32'd0, 10'd1023, 5'd0, 1'b1));
    plan.push_back(chk_row(1'b1, PKT_OTHER1, 32'hFFFF_FFFF, 10'd0, 5'd0, 1'b1));
    plan.push_back(cfg_row(32'd3, TIMEOUT_RST, 32'd5000, CHUNK_RST));
    plan.push_back(req_row(1'b0, PKT_OTHER0, 32'd0, 10'd0));
    plan.push_back(req_row(1'b1, ACK_TYPE, 32'd1, 10'd10));
    plan.push_back(req_row(1'b1, ACK_TYPE, 32'd0, 10'd10));
    plan.push_back(req_row(1'b1, PKT_OTHER2, 32'd0, 10'd1023));
    plan.push_back(req_row(1'b0, PKT_OTHER0, 32'd0, 10'd1023));
    plan.push_back(req_row(1'b1, ACK_TYPE, 32'hFFFF_FFFF, 10'd0));
    plan.push_back(req_row(1'b1, ACK_TYPE, 32'd3, 10'd0));
    plan.push_back(req_row(1'b1, ACK_TYPE, 32'd3, 10'd0));
    // closed window, every unacked entry resent each round
    plan.push_back(cfg_row(32'd0, 32'd0, 32'd5000, CHUNK_RST));
    plan.push_back(req_row(1'b0, PKT_OTHER0, 32'd0, 10'd0));
    // oversized window and zero chunk
    plan.push_back(cfg_row(32'd31, 32'd0, 32'd7000, 32'd0));
    plan.push_back(req_row(1'b0, PKT_OTHER1, 32'd0, 10'd5));
    plan.push_back(cfg_row(32'd16, 32'(AGE_MAX), 32'd6000, 32'd2047));
    plan.push_back(req_row(1'b1, ACK_TYPE, 32'd2, 10'd1023));
    plan.push_back(req_row(1'b0, PKT_OTHER0, 32'd0, 10'd1023));
    // transfer size dropped below what went out already
    plan.push_back(cfg_row(32'd16, TIMEOUT_RST, 32'd100, CHUNK_RST));
    plan.push_back(req_row(1'b0, PKT_OTHER0, 32'd0, 10'd0));
    plan.push_back(req_row(1'b1, ACK_TYPE, 32'h8000_0000, 10'd0));
    plan.push_back(req_row(1'b1, PKT_OTHER0, 32'h5555_5555, 10'd512));

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        program_regs(plan[i].win, plan[i].tmo, plan[i].total, plan[i].chunk);
      end else begin
        pace_sender();
        drive_request(plan[i].has_pkt, plan[i].ptype, plan[i].pseq, plan[i].el,
                      plan[i].typed, plan[i].occ, plan[i].done);
      end
    end

    // first phase keeps entries around long enough to saturate their age
    rand_items = 0;
    aging      = 1'b1;
    while (rand_items < RAND_ITEMS) begin
      wait_idle();
      if (aging) begin
        program_regs(32'd16, 32'(AGE_MAX), 32'hFFFF_FFFF, $urandom_range(1, 2047));
      end else begin
        case ($urandom_range(0, 9))
          0:       w = 32'd0;
          1:       w = 32'd1;
          2:       w = 32'd16;
          3:       w = 32'd31;
          default: w = $urandom_range(2, 16);
        endcase
        case ($urandom_range(0, 9))
          0:       t = 32'd0;
          1:       t = 32'd1;
          2:       t = 32'(AGE_MAX);
          default: t = $urandom_range(50, 3000);
        endcase
        case ($urandom_range(0, 9))
          0:       tot = 32'd0;
          1:       tot = 32'hFFFF_FFFF;
          2:       tot = bytes_out >> 1;
          3:       tot = bytes_out;
          default: tot = bytes_out + $urandom_range(0, 30000);
        endcase
        case ($urandom_range(0, 9))
          0:       ch = 32'd0;
          1:       ch = 32'd1;
          2:       ch = 32'(MAX_CHUNK);
          3:       ch = 32'd2047;
          default: ch = $urandom_range(1, 2047);
        endcase
        program_regs(w, t, tot, ch);
      end
      span      = aging ? 80 : $urandom_range(15, 50);
      ack_share = aging ? 15 : 55;
      for (int k = 0; k < span && rand_items < RAND_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (aging)
          el = ($urandom_range(0, 9) != 0) ? 10'd1023 : 10'($urandom_range(0, 1023));
        else
          case ($urandom_range(0, 9))
            0:       el = 10'd0;
            1:       el = 10'd1023;
            default: el = 10'($urandom_range(0, 1023));
          endcase
        if (pick < ack_share) begin
          // ack near the current window, mostly inside it
          h  = 1'b1;
          ty = ACK_TYPE;
          s  = base_seq + $urandom_range(0, DEPTH + 1);
        end else if (pick < ack_share + 15) begin
          h  = 1'b0;
          ty = 2'($urandom_range(0, 3));
          s  = $urandom;
        end else if (pick < ack_share + 30) begin
          h  = 1'b1;
          ty = 2'($urandom_range(0, 2));
          s  = $urandom;
        end else begin
          h  = 1'b1;
          ty = ACK_TYPE;
          s  = $urandom;
        end
        pace_sender();
        drive_request(h, ty, s, el, 1'b0, '0, 1'b0);
        rand_items++;
      end
      aging = 1'b0;
    end

    wait_idle();
    if (errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
